// ===== sv/ssmd_pkg.sv =====
// shared types, codes and segment table of the seven-segment display driver
package ssmd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PAD,
        ST_SHIFT
    } ssmd_state_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [7:0] SEG_ZERO = 8'hFC;
    localparam logic [7:0] SEG_DP   = 8'h01;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [16:0] DIV10_MAGIC = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [2:0] LAST_BIT = 3'd7;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0: pat = 8'hFC;
            4'd1: pat = 8'h60;
            4'd2: pat = 8'hDA;
            4'd3: pat = 8'hF2;
            4'd4: pat = 8'h66;
            4'd5: pat = 8'hB6;
            4'd6: pat = 8'hBE;
            4'd7: pat = 8'hE0;
            4'd8: pat = 8'hFE;
            4'd9: pat = 8'hF6;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

// ===== sv/ssmd_div10.sv =====
// one decimal digit step: quotient by ten and the segment pattern of the remainder
module ssmd_div10
    import ssmd_pkg::*;
(
    input  logic [15:0] value,
    output logic [15:0] quot,
    output logic [7:0]  pattern
);

    logic [32:0] prod;
    logic [15:0] times_ten;
    logic [15:0] rem_full;

    always_comb begin
        prod      = 33'(value) * 33'(DIV10_MAGIC);
        quot      = 16'(prod >> DIV10_SHIFT);
        times_ten = 16'(quot << 3) + 16'(quot << 1);
        rem_full  = value - times_ten;
        pattern   = seg_pattern(rem_full[3:0]);
    end

endmodule

// ===== sv/seven_segment_mux_driver.sv =====
// top level of the multiplexed seven-segment display driver
//
//  channel | ports                                               | direction
//  --------+-----------------------------------------------------+----------
//  s_      | s_valid s_ready s_cmd s_value s_decimals            | in
//  m_      | m_valid m_ready m_serial_bit m_latch_strobe          | out
//          | m_digit_select m_last                               |
//
// a load transaction is accepted in ST_IDLE, takes decimal digits (up to NUM_DIGITS) from
// the divide-by-ten step in ST_CONV, then adds the padding and the point in ST_PAD.
// a tick transaction gives eight result transactions, one bit per cycle while m_ready
// is high, from the output shift register.
// reset clears the stored patterns, shows digit 0 and sets the digit count to one.
// a stalled m_ready holds the current bit; no new transaction is taken until done.
module seven_segment_mux_driver
    import ssmd_pkg::*;
#(
    parameter int NUM_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [15:0] s_value,
    input  logic [1:0]  s_decimals,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_serial_bit,
    output logic        m_latch_strobe,
    output logic [3:0]  m_digit_select,
    output logic        m_last
);

    localparam int CNT_W = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [3:0] ND4 = 4'(NUM_DIGITS);

    ssmd_state_t state_reg, state_next;

    logic [7:0]       pat_reg  [NUM_DIGITS];
    logic [7:0]       pat_next [NUM_DIGITS];
    logic [CNT_W-1:0] dcount_reg, dcount_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      val_reg, val_next;
    logic [1:0]       dp_reg, dp_next;
    logic [7:0]       shift_reg, shift_next;
    logic [2:0]       bit_reg, bit_next;

    logic [15:0] quot;
    logic [7:0]  digit_pat;
    logic        take_digit;
    logic [3:0]  cnt4;
    logic [3:0]  need4;
    logic [3:0]  cur4;
    logic [3:0]  cur_inc4;
    logic [3:0]  sel;
    logic        fin;
    logic        s_fire;
    logic        m_fire;

    ssmd_div10 u_div10 (
        .value   (val_reg),
        .quot    (quot),
        .pattern (digit_pat)
    );

    always_comb begin
        s_fire     = s_valid && s_ready;
        m_fire     = m_valid && m_ready;
        fin        = (bit_reg == LAST_BIT);
        cnt4       = 4'(cnt_reg);
        take_digit = (cnt4 < ND4) && ((val_reg != 16'd0) || (cnt4 == 4'd0));
        // pad so the digit holding the point exists, capped at the store size
        if (dp_reg == 2'd0) begin
            need4 = 4'd0;
        end else if ((4'(dp_reg) + 4'd1) > ND4) begin
            need4 = ND4;
        end else begin
            need4 = 4'(dp_reg) + 4'd1;
        end
        cur4     = 4'(cur_reg);
        cur_inc4 = cur4 + 4'd1;
        sel      = (cur4 < 4'd4) ? (4'd1 << cur4) : 4'd0;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_cmd == CMD_LOAD) ? ST_CONV : ST_SHIFT;
                end
            end
            ST_CONV: begin
                if (!take_digit) begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                state_next = ST_IDLE;
            end
            ST_SHIFT: begin
                if (m_fire && fin) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        m_valid        = (state_reg == ST_SHIFT);
        m_serial_bit   = shift_reg[0];
        m_latch_strobe = fin;
        m_last         = fin;
        m_digit_select = fin ? sel : 4'd0;
    end

    // datapath
    always_comb begin
        pat_next    = pat_reg;
        dcount_next = dcount_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        val_next    = val_reg;
        dp_next     = dp_reg;
        shift_next  = shift_reg;
        bit_next    = bit_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_cmd == CMD_LOAD) begin
                        val_next = s_value;
                        dp_next  = s_decimals;
                        cnt_next = '0;
                    end else begin
                        shift_next = pat_reg[cur_reg];
                        bit_next   = '0;
                    end
                end
            end
            ST_CONV: begin
                if (take_digit) begin
                    pat_next[cnt_reg[IDX_W-1:0]] = digit_pat;
                    val_next = quot;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_PAD: begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    if (4'(i) >= cnt4) begin
                        pat_next[i] = (4'(i) < need4) ? SEG_ZERO : 8'h00;
                    end
                    if ((dp_reg != 2'd0) && (4'(dp_reg) == 4'(i))) begin
                        pat_next[i] = pat_next[i] | SEG_DP;
                    end
                end
                dcount_next = (need4 > cnt4) ? CNT_W'(need4) : cnt_reg;
                cur_next    = '0;
            end
            ST_SHIFT: begin
                if (m_fire) begin
                    shift_next = shift_reg >> 1;
                    bit_next   = bit_reg + 3'd1;
                    if (fin) begin
                        cur_next = (cur_inc4 >= 4'(dcount_reg)) ? '0 : IDX_W'(cur_inc4);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            dcount_reg <= CNT_W'(1);
            cur_reg    <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                pat_reg[i] <= 8'h00;
            end
        end else begin
            state_reg  <= state_next;
            dcount_reg <= dcount_next;
            cur_reg    <= cur_next;
            pat_reg    <= pat_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        val_reg   <= val_next;
        dp_reg    <= dp_next;
        shift_reg <= shift_next;
        bit_reg   <= bit_next;
    end

endmodule
